### rtl/rtbm_pkg.sv
// Package for the remap table merge block: field widths, codes, and the
// control word that travels down the lookup pipeline. No dependencies.
package rtbm_pkg;

    // Fixed field and register widths
    localparam int ROW_W   = 11;
    localparam int COL_W   = 12;
    localparam int LOAD_W  = 24;
    localparam int QX_W    = 20;
    localparam int QY_W    = 19;
    localparam int ENTRY_W = 16;
    localparam int OUT_W   = 24;

    // Neighbour indices, wide enough for a clamp bound of 4096
    localparam int IDX_W = 13;

    // Memory banks: even/odd row by even/odd column
    localparam int NBANK   = 4;
    localparam int WORD_W  = 2 * ENTRY_W;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration port
    localparam int   CFG_IDX_W  = 1;
    localparam int   CFG_DATA_W = 12;
    localparam logic REG_ACTIVE_COLS = 1'b0;
    localparam logic REG_ACTIVE_ROWS = 1'b1;
    localparam logic [COL_W-1:0] RESET_ACTIVE_COLS = 12'd2560;
    localparam logic [ROW_W-1:0] RESET_ACTIVE_ROWS = 11'd1440;

    // Control word handed from the address stage to the blend stages
    typedef struct packed {
        logic             valid;
        logic             query;
        logic [NBANK-1:0] we;
        logic             r0p;
        logic             r1p;
        logic             c0p;
        logic             c1p;
    } t_ctrl;

endpackage

### rtl/rtbm_req_if.sv
// Request channel of the remap table merge block: valid/ready and the
// load or query payload. Depends on nothing.
interface rtbm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [10:0] load_row;
    logic [11:0] load_col;
    logic [23:0] load_x;
    logic [23:0] load_y;
    logic [19:0] query_x;
    logic [18:0] query_y;

    modport source (
        output valid, req_type, load_row, load_col, load_x, load_y, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, load_row, load_col, load_x, load_y, query_x, query_y,
        output ready
    );
endinterface

### rtl/rtbm_res_if.sv
// Result channel of the remap table merge block: valid/ready and the
// merged coordinate pair. Depends on nothing.
interface rtbm_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] merged_x;
    logic [23:0] merged_y;

    modport source (output valid, merged_x, merged_y, input ready);
    modport sink (input valid, merged_x, merged_y, output ready);
endinterface

### rtl/remap_table_bilinear_merge.sv
// Top level of the remap table merge block: configuration registers,
// pipeline enable and the four store banks. Uses rtbm_pkg, rtbm_req_if,
// rtbm_res_if, rtbm_index, rtbm_bank and rtbm_blend.
//
//  channel   | direction | transaction
//  i_req     | in        | load one first-map entry, or query a merged point
//  o_res     | out       | merged x/y, one per query, none per load
//  i_cfg_*   | in        | write active_cols (index 0) or active_rows (1)
//
// One transaction per cycle while the output is not stalled. A query passes
// five register stages (clamp, address, store read, products, sum/round);
// the first captures at the accepting edge and the result is presented from
// the sum/round register. The store is split into four banks by row and
// column parity so the four neighbours are read in the same cycle.
// Reset clears control only; store contents are undefined until loaded.
// A stalled output freezes the whole pipeline; nothing is dropped.
module remap_table_bilinear_merge #(
    parameter int MAP_COLS  = 2560,
    parameter int MAP_ROWS  = 1440,
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rtbm_req_if.sink                          i_req,
    rtbm_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [rtbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rtbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rtbm_pkg::*;

    localparam int HR    = (MAP_ROWS + 1) / 2;
    localparam int HC    = (MAP_COLS + 1) / 2;
    localparam int DEPTH = HR * HC;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = 2 * FRAC_BITS + 1;
    localparam logic [IDX_W-1:0] COLS_I = IDX_W'(MAP_COLS);
    localparam logic [IDX_W-1:0] ROWS_I = IDX_W'(MAP_ROWS);
    localparam logic [IDX_W-1:0] TWO    = IDX_W'(2);

    logic [COL_W-1:0]   r_active_cols;
    logic [ROW_W-1:0]   r_active_rows;
    logic [IDX_W-1:0]   ac, ar, last_c, last_r;
    logic               en, res_valid;
    t_ctrl              ctrl;
    logic [AW-1:0]      addr [NBANK];
    logic [WORD_W-1:0]  wdata;
    logic [WW-1:0]      w [NBANK];
    logic [WORD_W-1:0]  rdata [NBANK];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cols <= RESET_ACTIVE_COLS;
            r_active_rows <= RESET_ACTIVE_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACTIVE_COLS: r_active_cols <= i_cfg_data[COL_W-1:0];
                REG_ACTIVE_ROWS: r_active_rows <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // last usable row and column, register bounded to [2, map size]
    always_comb begin
        ac = IDX_W'(r_active_cols);
        ar = IDX_W'(r_active_rows);
        last_c = ((ac < TWO) ? TWO : ((ac > COLS_I) ? COLS_I : ac)) - IDX_W'(1);
        last_r = ((ar < TWO) ? TWO : ((ar > ROWS_I) ? ROWS_I : ar)) - IDX_W'(1);
    end

    // whole pipeline advances unless a result is stuck
    assign en          = !res_valid || o_res.ready;
    assign i_req.ready = en;
    assign o_res.valid = res_valid;

    rtbm_index #(
        .MAP_COLS  (MAP_COLS),
        .MAP_ROWS  (MAP_ROWS),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .WW        (WW)
    ) u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_load_row (i_req.load_row),
        .i_load_col (i_req.load_col),
        .i_load_x   (i_req.load_x),
        .i_load_y   (i_req.load_y),
        .i_query_x  (i_req.query_x),
        .i_query_y  (i_req.query_y),
        .i_last_c   (last_c),
        .i_last_r   (last_r),
        .o_ctrl     (ctrl),
        .o_addr     (addr),
        .o_wdata    (wdata),
        .o_w        (w)
    );

    // store banks, indexed {row parity, column parity}
    for (genvar b = 0; b < NBANK; b++) begin : g_store
        rtbm_bank #(
            .DEPTH (DEPTH),
            .AW    (AW),
            .DW    (WORD_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (ctrl.we[b]),
            .i_addr  (addr[b]),
            .i_wdata (wdata),
            .o_rdata (rdata[b])
        );
    end

    rtbm_blend #(
        .FRAC_BITS (FRAC_BITS),
        .WW        (WW)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (ctrl),
        .i_w     (w),
        .i_rdata (rdata),
        .o_valid (res_valid),
        .o_mx    (o_res.merged_x),
        .o_my    (o_res.merged_y)
    );
endmodule

### rtl/rtbm_bank.sv
// One bank of the first-map store: single address port, with a write and a
// registered read per enabled cycle. Depends on nothing.
module rtbm_bank #(
    parameter int DEPTH = 921600,
    parameter int AW    = 20,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/rtbm_index.sv
// Front stages: entry rounding, neighbour clamping (stage 1), then bank
// addresses, write enables and bilinear weights (stage 2). Uses rtbm_pkg.
module rtbm_index #(
    parameter int MAP_COLS  = 2560,
    parameter int MAP_ROWS  = 1440,
    parameter int FRAC_BITS = 8,
    parameter int AW        = 20,
    parameter int WW        = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_req_type,
    input  logic [rtbm_pkg::ROW_W-1:0]    i_load_row,
    input  logic [rtbm_pkg::COL_W-1:0]    i_load_col,
    input  logic [rtbm_pkg::LOAD_W-1:0]   i_load_x,
    input  logic [rtbm_pkg::LOAD_W-1:0]   i_load_y,
    input  logic [rtbm_pkg::QX_W-1:0]     i_query_x,
    input  logic [rtbm_pkg::QY_W-1:0]     i_query_y,
    input  logic [rtbm_pkg::IDX_W-1:0]    i_last_c,
    input  logic [rtbm_pkg::IDX_W-1:0]    i_last_r,
    output rtbm_pkg::t_ctrl               o_ctrl,
    output logic [AW-1:0]                 o_addr [rtbm_pkg::NBANK],
    output logic [rtbm_pkg::WORD_W-1:0]   o_wdata,
    output logic [WW-1:0]                 o_w [rtbm_pkg::NBANK]
);
    import rtbm_pkg::*;

    localparam int HC   = (MAP_COLS + 1) / 2;
    localparam int FW   = FRAC_BITS + 1;
    localparam int CW   = QX_W + 1;
    localparam int RW   = QY_W + 1;
    localparam int MW   = LOAD_W + 1;
    localparam logic [AW-1:0]    HC_A   = AW'(HC);
    localparam logic [FW-1:0]    ONE    = FW'(1) << FRAC_BITS;
    localparam logic [MW-1:0]    HALF_E = MW'(1) << (FRAC_BITS - 1);
    localparam logic [IDX_W-1:0] ROWS_I = IDX_W'(MAP_ROWS);
    localparam logic [IDX_W-1:0] COLS_I = IDX_W'(MAP_COLS);

    // Round a load value to an integer, halves away from zero, saturate to 16 bits
    function automatic logic [ENTRY_W-1:0] round_entry(input logic [LOAD_W-1:0] a);
        logic          neg;
        logic [MW-1:0] m;
        logic [MW-1:0] r;
        neg = a[LOAD_W-1];
        m = neg ? (MW'(0) - {a[LOAD_W-1], a}) : {1'b0, a};
        r = (m + HALF_E) >> FRAC_BITS;
        if (neg) begin
            round_entry = (r > MW'(32768)) ? 16'h8000 : ENTRY_W'(MW'(0) - r);
        end else begin
            round_entry = (r > MW'(32767)) ? 16'h7fff : r[ENTRY_W-1:0];
        end
    endfunction

    // stage 1 registers
    logic                 r1_valid, r1_query, r1_wok;
    logic [IDX_W-1:0]     r1_r0, r1_r1, r1_c0, r1_c1;
    logic [FRAC_BITS-1:0] r1_fx, r1_fy;
    logic [ENTRY_W-1:0]   r1_ex, r1_ey;
    logic [IDX_W-1:0]     n1_r0, n1_r1, n1_c0, n1_c1;
    logic                 n1_wok;
    logic [CW-1:0]        q_c0, q_c1;
    logic [RW-1:0]        q_r0, q_r1;

    // stage 2 registers
    t_ctrl                r2_ctrl;
    logic [AW-1:0]        r2_addr [NBANK];
    logic [WORD_W-1:0]    r2_wdata;
    logic [WW-1:0]        r2_w [NBANK];
    t_ctrl                n2_ctrl;
    logic [AW-1:0]        n2_addr [NBANK];
    logic [WW-1:0]        n2_w [NBANK];
    logic [FW-1:0]        omfx, omfy, fx_e, fy_e;

    // neighbour indices, clamped to the last active row and column
    always_comb begin
        q_c0 = CW'(i_query_x >> FRAC_BITS);
        q_c1 = q_c0 + CW'(1);
        q_r0 = RW'(i_query_y >> FRAC_BITS);
        q_r1 = q_r0 + RW'(1);
        n1_wok = (IDX_W'(i_load_row) < ROWS_I) && (IDX_W'(i_load_col) < COLS_I);
        if (i_req_type == REQ_QUERY) begin
            n1_c0 = (q_c0 > CW'(i_last_c)) ? i_last_c : q_c0[IDX_W-1:0];
            n1_c1 = (q_c1 > CW'(i_last_c)) ? i_last_c : q_c1[IDX_W-1:0];
            n1_r0 = (q_r0 > RW'(i_last_r)) ? i_last_r : q_r0[IDX_W-1:0];
            n1_r1 = (q_r1 > RW'(i_last_r)) ? i_last_r : q_r1[IDX_W-1:0];
        end else begin
            n1_c0 = IDX_W'(i_load_col);
            n1_c1 = IDX_W'(i_load_col);
            n1_r0 = IDX_W'(i_load_row);
            n1_r1 = IDX_W'(i_load_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_query <= i_req_type;
            r1_wok   <= n1_wok;
            r1_r0    <= n1_r0;
            r1_r1    <= n1_r1;
            r1_c0    <= n1_c0;
            r1_c1    <= n1_c1;
            r1_fx    <= i_query_x[FRAC_BITS-1:0];
            r1_fy    <= i_query_y[FRAC_BITS-1:0];
            r1_ex    <= round_entry(i_load_x);
            r1_ey    <= round_entry(i_load_y);
        end
    end

    // per-bank addresses and write enables
    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        logic [IDX_W-1:0] row, col;
        assign row = (r1_r0[0] == b[1]) ? r1_r0 : r1_r1;
        assign col = (r1_c0[0] == b[0]) ? r1_c0 : r1_c1;
        assign n2_addr[b] = AW'(row[IDX_W-1:1]) * HC_A + AW'(col[IDX_W-1:1]);
        assign n2_ctrl.we[b] = r1_valid && (r1_query == REQ_LOAD) && r1_wok
                               && (r1_r0[0] == b[1]) && (r1_c0[0] == b[0]);
    end

    // bilinear weights, order (r0,c0) (r0,c1) (r1,c0) (r1,c1)
    always_comb begin
        fx_e    = FW'(r1_fx);
        fy_e    = FW'(r1_fy);
        omfx    = ONE - fx_e;
        omfy    = ONE - fy_e;
        n2_w[0] = WW'(omfx * omfy);
        n2_w[1] = WW'(fx_e * omfy);
        n2_w[2] = WW'(omfx * fy_e);
        n2_w[3] = WW'(fx_e * fy_e);
    end

    assign n2_ctrl.valid = r1_valid;
    assign n2_ctrl.query = r1_query;
    assign n2_ctrl.r0p   = r1_r0[0];
    assign n2_ctrl.r1p   = r1_r1[0];
    assign n2_ctrl.c0p   = r1_c0[0];
    assign n2_ctrl.c1p   = r1_c1[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctrl <= '0;
        end else if (i_en) begin
            r2_ctrl <= n2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_addr  <= n2_addr;
            r2_w     <= n2_w;
            r2_wdata <= {r1_ex, r1_ey};
        end
    end

    assign o_ctrl  = r2_ctrl;
    assign o_addr  = r2_addr;
    assign o_wdata = r2_wdata;
    assign o_w     = r2_w;

    // writes only come from valid load transactions
    a_we_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_ctrl.we != '0) |-> (r2_ctrl.valid && (r2_ctrl.query == REQ_LOAD)))
        else $error("bank write from a non-load transaction");

    // clamped neighbours are equal or adjacent
    a_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && (r1_query == REQ_QUERY)) |->
        ((r1_c1 == r1_c0) || (r1_c1 == r1_c0 + IDX_W'(1))) &&
        ((r1_r1 == r1_r0) || (r1_r1 == r1_r0 + IDX_W'(1))))
        else $error("neighbour indices not adjacent");

    // a stall holds the control word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r2_ctrl))
        else $error("control word moved during stall");
endmodule

### rtl/rtbm_blend.sv
// Back stages: neighbour selection and weight products (stage 4), sum,
// rounding and saturation into the output register (stage 5). Uses rtbm_pkg.
module rtbm_blend #(
    parameter int FRAC_BITS = 8,
    parameter int WW        = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  rtbm_pkg::t_ctrl               i_ctrl,
    input  logic [WW-1:0]                 i_w [rtbm_pkg::NBANK],
    input  logic [rtbm_pkg::WORD_W-1:0]   i_rdata [rtbm_pkg::NBANK],
    output logic                          o_valid,
    output logic [rtbm_pkg::OUT_W-1:0]    o_mx,
    output logic [rtbm_pkg::OUT_W-1:0]    o_my
);
    import rtbm_pkg::*;

    localparam int PW = WW + 1 + ENTRY_W;
    localparam int SW = PW + 2;
    localparam logic [SW-1:0] HALF    = SW'(1) << (FRAC_BITS - 1);
    localparam logic [SW-1:0] LIM_POS = SW'(8388607);
    localparam logic [SW-1:0] LIM_NEG = SW'(8388608);
    localparam logic [WW+1:0] W_SUM   = (WW + 2)'(1) << (2 * FRAC_BITS);

    // Divide by 2^FRAC_BITS, halves away from zero, saturate to 24 bits
    function automatic logic [OUT_W-1:0] round_out(input logic [SW-1:0] a);
        logic          neg;
        logic [SW-1:0] m;
        logic [SW-1:0] r;
        neg = a[SW-1];
        m = neg ? (SW'(0) - a) : a;
        r = (m + HALF) >> FRAC_BITS;
        if (neg) begin
            round_out = (r > LIM_NEG) ? 24'h800000 : OUT_W'(SW'(0) - r);
        end else begin
            round_out = (r > LIM_POS) ? 24'h7fffff : r[OUT_W-1:0];
        end
    endfunction

    // stage 3: align control and weights with the bank read data
    t_ctrl              r3_ctrl;
    logic [WW-1:0]      r3_w [NBANK];

    // stage 4: products
    logic               r4_valid;
    logic [PW-1:0]      r4_px [NBANK];
    logic [PW-1:0]      r4_py [NBANK];
    logic [PW-1:0]      n4_px [NBANK];
    logic [PW-1:0]      n4_py [NBANK];

    // stage 5: output register
    logic               r5_valid;
    logic [OUT_W-1:0]   r5_x, r5_y;
    logic [SW-1:0]      sum_x, sum_y;
    logic [WW+1:0]      w_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctrl  <= '0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r3_ctrl  <= i_ctrl;
            r4_valid <= r3_ctrl.valid && (r3_ctrl.query == REQ_QUERY);
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_w <= i_w;
        end
    end

    // pick each neighbour's bank by row/column parity, then weight it
    for (genvar k = 0; k < NBANK; k++) begin : g_nb
        logic                      rp, cp;
        logic [WORD_W-1:0]         word;
        logic signed [PW-1:0]      wa, vx, vy;
        assign rp   = k[1] ? r3_ctrl.r1p : r3_ctrl.r0p;
        assign cp   = k[0] ? r3_ctrl.c1p : r3_ctrl.c0p;
        assign word = i_rdata[{rp, cp}];
        assign wa   = PW'(r3_w[k]);
        assign vx   = PW'($signed(word[WORD_W-1:ENTRY_W]));
        assign vy   = PW'($signed(word[ENTRY_W-1:0]));
        assign n4_px[k] = PW'(wa * vx);
        assign n4_py[k] = PW'(wa * vy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_px <= n4_px;
            r4_py <= n4_py;
        end
    end

    // sum of the four weighted neighbours
    always_comb begin
        sum_x = SW'($signed(r4_px[0])) + SW'($signed(r4_px[1]))
              + SW'($signed(r4_px[2])) + SW'($signed(r4_px[3]));
        sum_y = SW'($signed(r4_py[0])) + SW'($signed(r4_py[1]))
              + SW'($signed(r4_py[2])) + SW'($signed(r4_py[3]));
        w_total = (WW + 2)'(r3_w[0]) + (WW + 2)'(r3_w[1])
                + (WW + 2)'(r3_w[2]) + (WW + 2)'(r3_w[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_x <= round_out(sum_x);
            r5_y <= round_out(sum_y);
        end
    end

    assign o_valid = r5_valid;
    assign o_mx    = r5_x;
    assign o_my    = r5_y;

    // weights of a query always sum to one
    a_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_ctrl.valid && (r3_ctrl.query == REQ_QUERY)) |-> (w_total == W_SUM))
        else $error("bilinear weights do not sum to one");

    // a load transaction never yields a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r3_ctrl.valid && (r3_ctrl.query == REQ_LOAD)) |=> !r4_valid)
        else $error("load transaction produced a result");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

### sim/tb_remap_table_bilinear_merge.sv
// Self-checking testbench for remap_table_bilinear_merge: drives load and query
// transactions, predicts each merged coordinate and checks results in order.
// Depends on rtbm_pkg, rtbm_req_if, rtbm_res_if and the block itself.
`timescale 1ns / 100ps

module tb_remap_table_bilinear_merge;
    import rtbm_pkg::*;

    localparam int MAP_COLS  = 2560;
    localparam int MAP_ROWS  = 1440;
    localparam int FRAC      = 8;
    localparam int HOLD_LEN  = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_PHASES  = 8;

    typedef struct {
        logic        req_type;
        logic [10:0] row;
        logic [11:0] col;
        logic [23:0] lx;
        logic [23:0] ly;
        logic [19:0] qx;
        logic [18:0] qy;
    } t_req;

    typedef struct {
        logic [23:0] mx;
        logic [23:0] my;
    } t_merged;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rtbm_req_if rq();
    rtbm_res_if rs();

    remap_table_bilinear_merge uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (rq),
        .o_res      (rs),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the map store and registers, plus the generator's view of
    // which entries have been written
    int      map_x [int];
    int      map_y [int];
    bit      loaded [int];
    int      cols_reg = 2560;
    int      rows_reg = 1440;
    t_req    pending [$];
    t_merged merged_due [$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  pressure_armed = 0;
    bit  pressure_seen = 0;
    int  hold_cnt = 0;
    bit  req_taken = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;

    function automatic int last_index(int v, int lim);
        if (v < 2) v = 2;
        if (v > lim) v = lim;
        return v - 1;
    endfunction

    function automatic int clamp_to(int v, int last);
        return (v > last) ? last : v;
    endfunction

    // Divide by 2^s, halves away from zero
    function automatic longint round_away(longint a, int s);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int to_entry(logic [23:0] v);
        return int'(sat(round_away(longint'($signed(v)), FRAC), -32768, 32767));
    endfunction

    function automatic logic [23:0] blend(int s00, int s10, int s01, int s11,
                                          longint fx, longint fy);
        longint one;
        longint acc;
        one = longint'(1) << FRAC;
        acc = (one - fx) * (one - fy) * s00 + (one - fx) * fy * s10
            + fx * (one - fy) * s01 + fx * fy * s11;
        return 24'(sat(round_away(acc, FRAC), -8388608, 8388607));
    endfunction

    // Apply one accepted transaction to the shadow; queries queue a result
    function automatic void predict(t_req it);
        int lc, lr, c0, c1, r0, r1, a;
        longint fx, fy;
        t_merged m;
        if (it.req_type == REQ_LOAD) begin
            if (it.row < MAP_ROWS && it.col < MAP_COLS) begin
                a = it.row * MAP_COLS + it.col;
                map_x[a] = to_entry(it.lx);
                map_y[a] = to_entry(it.ly);
            end
            return;
        end
        lc = last_index(cols_reg, MAP_COLS);
        lr = last_index(rows_reg, MAP_ROWS);
        c0 = clamp_to(it.qx >> FRAC, lc);
        c1 = clamp_to((it.qx >> FRAC) + 1, lc);
        r0 = clamp_to(it.qy >> FRAC, lr);
        r1 = clamp_to((it.qy >> FRAC) + 1, lr);
        fx = it.qx[FRAC-1:0];
        fy = it.qy[FRAC-1:0];
        m.mx = blend(map_x[r0*MAP_COLS+c0], map_x[r1*MAP_COLS+c0],
                     map_x[r0*MAP_COLS+c1], map_x[r1*MAP_COLS+c1], fx, fy);
        m.my = blend(map_y[r0*MAP_COLS+c0], map_y[r1*MAP_COLS+c0],
                     map_y[r0*MAP_COLS+c1], map_y[r1*MAP_COLS+c1], fx, fy);
        merged_due.push_back(m);
    endfunction

    function automatic logic [23:0] rand_value();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return {16'($urandom_range(255)), 8'h80};
            3: return 24'(int'($urandom_range(65535)) - 32768);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void push_load(int row, int col, logic [23:0] x,
                                      logic [23:0] y);
        t_req it;
        it = '{REQ_LOAD, 11'(row), 12'(col), x, y, 20'($urandom), 19'($urandom)};
        if (row < MAP_ROWS && col < MAP_COLS)
            loaded[row * MAP_COLS + col] = 1;
        pending.push_back(it);
    endfunction

    // Queue a query, loading first any neighbour that has never been written
    function automatic void push_query(logic [19:0] qx, logic [18:0] qy);
        int lc, lr, r, c;
        int cs [2];
        int rws [2];
        t_req it;
        lc = last_index(cols_reg, MAP_COLS);
        lr = last_index(rows_reg, MAP_ROWS);
        cs[0] = clamp_to(qx >> FRAC, lc);
        cs[1] = clamp_to((qx >> FRAC) + 1, lc);
        rws[0] = clamp_to(qy >> FRAC, lr);
        rws[1] = clamp_to((qy >> FRAC) + 1, lr);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
                r = rws[i];
                c = cs[j];
                if (!loaded.exists(r * MAP_COLS + c))
                    push_load(r, c, rand_value(), rand_value());
            end
        it = '{REQ_QUERY, 11'($urandom), 12'($urandom), 24'($urandom), 24'($urandom),
               qx, qy};
        pending.push_back(it);
    endfunction

    function automatic int pick_base(int last, int width_max);
        int near_lim;
        near_lim = (last < 20) ? last + 1 : 20;
        case ($urandom_range(19))
            0, 1, 2: return $urandom_range(width_max);
            3, 4, 5: return last - 1 + $urandom_range(3);
            default: return $urandom_range(near_lim);
        endcase
    endfunction

    function automatic int pick_frac();
        case ($urandom_range(7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        if (idx == REG_ACTIVE_COLS) cols_reg = value & 12'hFFF;
        else rows_reg = value & 11'h7FF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending.size() == 0 && !rq.valid && merged_due.size() == 0);
        repeat (12) @(posedge i_clk);
    endtask

    // Sender: hold each transaction until taken, gaps at random
    always @(negedge i_clk) begin
        t_req it;
        if (i_rst_n && (!rq.valid || req_taken)) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending.pop_front();
                rq.req_type <= it.req_type;
                rq.load_row <= it.row;
                rq.load_col <= it.col;
                rq.load_x   <= it.lx;
                rq.load_y   <= it.ly;
                rq.query_x  <= it.qx;
                rq.query_y  <= it.qy;
                rq.valid    <= 1'b1;
            end else begin
                rq.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once
    always @(negedge i_clk) begin
        if (pressure_armed && !pressure_seen) begin
            hold_cnt      <= HOLD_LEN;
            pressure_seen <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Receiver ready
    always @(negedge i_clk) begin
        if (i_rst_n)
            rs.ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
    end

    // Handshake sampling, prediction and result checking
    always @(posedge i_clk) begin
        t_req it;
        t_merged m;
        req_taken = rq.valid && rq.ready;
        if (req_taken) begin
            it = '{rq.req_type, rq.load_row, rq.load_col, rq.load_x, rq.load_y,
                   rq.query_x, rq.query_y};
            predict(it);
        end
        if (rs.valid && rs.ready) begin
            if (merged_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h", rs.merged_x, rs.merged_y);
            end else begin
                m = merged_due.pop_front();
                if (rs.merged_x !== m.mx || rs.merged_y !== m.my) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h, got x=%h y=%h",
                                 m.mx, m.my, rs.merged_x, rs.merged_y);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((rq.valid && rq.ready) || (rs.valid && rs.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("remap_table_bilinear_merge verification failed");
            $finish;
        end
    end

    // Stimulus and phase sequencing
    initial begin
        int cfg_cols [N_PHASES] = '{2, 0, 4095, 2560, 7, 16, 3, 2560};
        int cfg_rows [N_PHASES] = '{2, 1, 2047, 1440, 5, 9, 1440, 2};
        int idle_tab [4] = '{0, 67, 0, 29};
        int stall_tab [4] = '{0, 0, 67, 29};
        int lc, lr;
        rq.valid   = 1'b0;
        rq.req_type = REQ_LOAD;
        rq.load_row = '0;
        rq.load_col = '0;
        rq.load_x   = '0;
        rq.load_y   = '0;
        rq.query_x  = '0;
        rq.query_y  = '0;
        rs.ready   = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_ACTIVE_COLS;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: rounding halves, saturation, ignored loads, edge queries
        push_load(0, 0, 24'h000080, 24'hFFFF80);
        push_load(0, 1, 24'h7FFFFF, 24'h800000);
        push_load(1, 0, 24'h00017F, 24'hFFFE80);
        push_load(1, 1, 24'h000000, 24'hFFFFFF);
        push_load(1440, 5, 24'h001000, 24'h001000);
        push_load(7, 2560, 24'h001000, 24'h001000);
        push_load(2047, 4095, 24'h001000, 24'h001000);
        push_query(20'h00000, 19'h00000);
        push_query(20'h000FF, 19'h000FF);
        push_query(20'h00080, 19'h00080);
        push_query(20'h0007F, 19'h00001);
        push_query(20'hFFFFF, 19'h7FFFF);
        push_query(20'h9FF80, 19'h59F40);
        push_query(20'h9FE80, 19'h59E10);
        push_query(20'hA0000, 19'h5A000);
        push_query(20'h00000, 19'h5A000);
        push_load(1439, 2559, 24'h800000, 24'h7FFFFF);
        push_query(20'h9FFFF, 19'h59FFF);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(REG_ACTIVE_COLS, cfg_cols[p]);
            write_reg(REG_ACTIVE_ROWS, cfg_rows[p]);
            send_idle_pct = idle_tab[p % 4];
            stall_pct     = stall_tab[p % 4];
            lc = last_index(cols_reg, MAP_COLS);
            lr = last_index(rows_reg, MAP_ROWS);
            for (int n = 0; n < 120; n++) begin
                case ($urandom_range(19))
                    0:
                        push_load($urandom_range(2047), $urandom_range(4095),
                                  rand_value(), rand_value());
                    1, 2, 3, 4:
                        push_load(clamp_to(pick_base(lr, 1439), lr),
                                  clamp_to(pick_base(lc, 2559), lc),
                                  rand_value(), rand_value());
                    default:
                        push_query(20'(pick_base(lc, 4095) * 256 + pick_frac()),
                                   19'(pick_base(lr, 2047) * 256 + pick_frac()));
                endcase
            end
            if (p == 2) pressure_armed = 1'b1;
            drain();
        end

        if (mismatches == 0)
            $display("remap_table_bilinear_merge verification clean");
        else
            $display("remap_table_bilinear_merge verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/rtbm_pkg.sv
rtl/rtbm_req_if.sv
rtl/rtbm_res_if.sv
rtl/rtbm_bank.sv
rtl/rtbm_index.sv
rtl/rtbm_blend.sv
rtl/remap_table_bilinear_merge.sv
sim/tb_remap_table_bilinear_merge.sv
